@@ hdl/gcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Great-circle bearing difference package
// Shared widths, the CORDIC vector type and elaboration-time angle constants.
// ----------------------------------------------------------------------------
package gcbd_pkg;

  // Angle word: signed radians, wide enough for a longitude difference.
  localparam int ANG_W = 34;
  // CORDIC x/y word: Q30 values with headroom for gain and atan2 pre-rotation.
  localparam int VEC_W = 34;
  // Sine and cosine word after the rotation chains (Q30).
  localparam int SC_W = 32;
  // Fraction bits of sines, cosines and their products.
  localparam int PROD_SHIFT = 30;

  // Pi with 60 fraction bits.
  localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;

  // Start value of x in rotation mode: the inverse CORDIC gain in Q30.
  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = VEC_W'(652032874);

  // Data that one CORDIC cell hands to the next.
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    flag;
  } cordic_vec_t;

  // Round a Q60 value to nearest at the given number of fraction bits.
  function automatic logic signed [63:0] q60_to_angle(input logic signed [63:0] v,
                                                      input int frac);
    int sh;
    sh = 60 - frac;
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [63:0] angle_pi(input int frac);
    return q60_to_angle(PI_Q60, frac);
  endfunction

  function automatic logic signed [63:0] angle_half_pi(input int frac);
    return q60_to_angle(PI_Q60 >>> 1, frac);
  endfunction

  function automatic logic signed [63:0] angle_two_pi(input int frac);
    return q60_to_angle(PI_Q60 <<< 1, frac);
  endfunction

  // Quotient of a non-negative dividend by a positive divisor, by long division.
  function automatic logic signed [63:0] div_pos(input logic signed [63:0] num,
                                                 input logic signed [63:0] den);
    logic signed [63:0] quo;
    logic signed [63:0] rem;
    quo = 64'sd0;
    rem = 64'sd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem <<< 1) | 64'(num[b]);
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q60 from its power series; only evaluated at elaboration.
  function automatic logic signed [63:0] atan_q60(input int i);
    logic signed [63:0] acc;
    logic signed [63:0] term;
    int k;
    acc = 64'sd0;
    if (i == 0) begin
      acc = PI_Q60 >>> 2;
    end else begin
      for (k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
        term = div_pos(64'sd1 <<< (60 - i * (2 * k + 1)), 64'(2 * k + 1));
        if ((k % 2) == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  function automatic logic signed [63:0] atan_angle(input int i, input int frac);
    return q60_to_angle(atan_q60(i), frac);
  endfunction

endpackage

@@ hdl/gcbd_angle_reduce.sv @@
// ----------------------------------------------------------------------------
// Angle reduction front end
// Brings an angle into [-pi/2, pi/2] with a sign flag, ready for a rotation
// chain: truncating remainder by 2pi, wrap into [-pi, pi], then half-turn fold.
// ----------------------------------------------------------------------------
module gcbd_angle_reduce
  import gcbd_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [ANG_W-1:0] angle_i,
  output cordic_vec_t             vec_o
);

  localparam logic signed [ANG_W-1:0] PI_C = ANG_W'(angle_pi(FRAC_BITS));
  localparam logic signed [ANG_W-1:0] HP_C = ANG_W'(angle_half_pi(FRAC_BITS));
  localparam logic signed [ANG_W-1:0] TP_C = ANG_W'(angle_two_pi(FRAC_BITS));
  localparam logic signed [ANG_W-1:0] TP_MINUS_HP = TP_C - HP_C;
  localparam logic signed [ANG_W-1:0] HP_MINUS_TP = HP_C - TP_C;
  localparam logic signed [ANG_W-1:0] PI_MINUS_TP = PI_C - TP_C;
  localparam logic signed [ANG_W-1:0] TP_MINUS_PI = TP_C - PI_C;
  localparam logic [31:0] TP_U  = 32'(angle_two_pi(FRAC_BITS));
  // floor(2^32 / 2pi): the quotient estimate is exact or one low.
  localparam logic [31:0] RECIP = 32'((64'sd1 <<< 32) / angle_two_pi(FRAC_BITS));

  // Stage 1: magnitude and reciprocal multiply.
  logic        sign_s1_q;
  logic [31:0] abs_s1_q;
  logic [63:0] prod_s1_q;
  logic [31:0] abs_d;

  always_comb begin
    if (angle_i[ANG_W-1]) begin
      abs_d = 32'(-angle_i);
    end else begin
      abs_d = 32'(angle_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign_s1_q <= angle_i[ANG_W-1];
      abs_s1_q  <= abs_d;
      prod_s1_q <= 64'(abs_d) * 64'(RECIP);
    end
  end

  // Stage 2: quotient times 2pi.
  logic        sign_s2_q;
  logic [31:0] abs_s2_q;
  logic [63:0] qt_s2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign_s2_q <= sign_s1_q;
      abs_s2_q  <= abs_s1_q;
      qt_s2_q   <= 64'(prod_s1_q[63:32]) * 64'(TP_U);
    end
  end

  // Stage 3: remainder with one correction step, sign of the dividend.
  logic signed [ANG_W-1:0] rem0;
  logic signed [ANG_W-1:0] rem1;
  logic signed [ANG_W-1:0] rem;
  logic signed [ANG_W-1:0] r_s3_q;

  always_comb begin
    rem0 = ANG_W'(abs_s2_q) - ANG_W'(qt_s2_q);
    rem1 = rem0 - TP_C;
    rem  = rem1[ANG_W-1] ? rem0 : rem1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_s3_q <= sign_s2_q ? -rem : rem;
    end
  end

  // Stage 4: wrap into [-pi, pi] and fold into [-pi/2, pi/2].
  logic signed [ANG_W-1:0] z_d;
  logic                    neg_d;

  always_comb begin
    z_d   = r_s3_q;
    neg_d = 1'b0;
    if (r_s3_q > PI_C) begin
      if (r_s3_q < TP_MINUS_HP) begin
        z_d   = r_s3_q + PI_MINUS_TP;
        neg_d = 1'b1;
      end else begin
        z_d = r_s3_q - TP_C;
      end
    end else if (r_s3_q < -PI_C) begin
      if (r_s3_q > HP_MINUS_TP) begin
        z_d   = r_s3_q + TP_MINUS_PI;
        neg_d = 1'b1;
      end else begin
        z_d = r_s3_q + TP_C;
      end
    end else if (r_s3_q > HP_C) begin
      z_d   = r_s3_q - PI_C;
      neg_d = 1'b1;
    end else if (r_s3_q < -HP_C) begin
      z_d   = r_s3_q + PI_C;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_o.x    <= CORDIC_GAIN;
      vec_o.y    <= '0;
      vec_o.z    <= z_d;
      vec_o.flag <= neg_d;
    end
  end

endmodule

@@ hdl/gcbd_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation by atan(2^-STAGE), in rotation or vectoring mode,
// registered and handed to the next cell of the chain.
// ----------------------------------------------------------------------------
module gcbd_cordic_cell
  import gcbd_pkg::*;
#(
  parameter int STAGE     = 0,
  parameter bit VECTORING = 1'b0,
  parameter int FRAC_BITS = 28
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  cordic_vec_t vec_i,
  output cordic_vec_t vec_o
);

  localparam logic signed [ANG_W-1:0] ATAN_C = ANG_W'(atan_angle(STAGE, FRAC_BITS));

  logic signed [VEC_W-1:0] x_in;
  logic signed [VEC_W-1:0] y_in;
  logic signed [ANG_W-1:0] z_in;
  logic signed [VEC_W-1:0] x_sh;
  logic signed [VEC_W-1:0] y_sh;
  logic                    ccw;

  // Rotation steers by the sign of z, vectoring by the sign of y.
  always_comb begin
    x_in = vec_i.x;
    y_in = vec_i.y;
    z_in = vec_i.z;
    x_sh = x_in >>> STAGE;
    y_sh = y_in >>> STAGE;
    if (VECTORING) begin
      ccw = y_in[VEC_W-1];
    end else begin
      ccw = ~z_in[ANG_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_o.flag <= vec_i.flag;
      if (ccw) begin
        vec_o.x <= x_in - y_sh;
        vec_o.y <= y_in + x_sh;
        vec_o.z <= z_in - ATAN_C;
      end else begin
        vec_o.x <= x_in + y_sh;
        vec_o.y <= y_in - x_sh;
        vec_o.z <= z_in + ATAN_C;
      end
    end
  end

endmodule

@@ hdl/great_circle_bearing_difference.sv @@
// Throughput: one item per cycle; all stages advance together and freeze only while the
// output skid register is full, so one result may wait without stalling the input.
// Two CORDIC levels in series: three sin/cos chains in parallel, then two atan2 chains.
// Reset (rst_ni low, asynchronous) empties the pipeline, output and skid registers.
// ----------------------------------------------------------------------------
// Great-circle bearing difference
// Initial minus final bearing between a reference position and a station,
// built from CORDIC sin/cos chains, product stages and CORDIC atan2 chains.
// ----------------------------------------------------------------------------
module great_circle_bearing_difference
  import gcbd_pkg::*;
#(
  parameter int FRAC_BITS     = 28,
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] ref_longitude_i,
  input  logic signed [29:0] ref_latitude_i,
  input  logic signed [30:0] site_longitude_i,
  input  logic signed [29:0] site_latitude_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] azimuth_offset_o
);

  localparam int PIPE_LEN = 12 + 2 * CORDIC_STAGES;
  localparam logic signed [ANG_W-1:0] PI_C      = ANG_W'(angle_pi(FRAC_BITS));
  localparam logic signed [ANG_W-1:0] HALF_PI_C = ANG_W'(angle_half_pi(FRAC_BITS));
  localparam logic signed [ANG_W-1:0] TWO_PI_C  = ANG_W'(angle_two_pi(FRAC_BITS));

  logic                adv;
  logic [PIPE_LEN-1:0] vld_q;

  // Whole pipeline moves unless the skid register is occupied.
  logic skid_vld_q;
  assign adv        = ~skid_vld_q;
  assign in_ready_o = adv;

  // Valid row that follows the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LEN-2:0], in_valid_i};
    end
  end

  // Input stage: longitude difference and latitudes.
  logic signed [ANG_W-1:0] dlon_q;
  logic signed [ANG_W-1:0] rlat_q;
  logic signed [ANG_W-1:0] slat_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlon_q <= ANG_W'(ref_longitude_i) - ANG_W'(site_longitude_i);
      rlat_q <= ANG_W'(ref_latitude_i);
      slat_q <= ANG_W'(site_latitude_i);
    end
  end

  // Angle reduction and sin/cos chains for the three angles.
  cordic_vec_t rot_dl [CORDIC_STAGES+1];
  cordic_vec_t rot_rl [CORDIC_STAGES+1];
  cordic_vec_t rot_sl [CORDIC_STAGES+1];

  gcbd_angle_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_dl (
    .clk_i, .en_i(adv), .angle_i(dlon_q), .vec_o(rot_dl[0])
  );
  gcbd_angle_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_rl (
    .clk_i, .en_i(adv), .angle_i(rlat_q), .vec_o(rot_rl[0])
  );
  gcbd_angle_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_sl (
    .clk_i, .en_i(adv), .angle_i(slat_q), .vec_o(rot_sl[0])
  );

  genvar g;
  for (g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    gcbd_cordic_cell #(.STAGE(g), .VECTORING(1'b0), .FRAC_BITS(FRAC_BITS)) u_dl (
      .clk_i, .en_i(adv), .vec_i(rot_dl[g]), .vec_o(rot_dl[g+1])
    );
    gcbd_cordic_cell #(.STAGE(g), .VECTORING(1'b0), .FRAC_BITS(FRAC_BITS)) u_rl (
      .clk_i, .en_i(adv), .vec_i(rot_rl[g]), .vec_o(rot_rl[g+1])
    );
    gcbd_cordic_cell #(.STAGE(g), .VECTORING(1'b0), .FRAC_BITS(FRAC_BITS)) u_sl (
      .clk_i, .en_i(adv), .vec_i(rot_sl[g]), .vec_o(rot_sl[g+1])
    );
  end

  // Undo the half-turn fold: negate sine and cosine where it was applied.
  logic signed [VEC_W-1:0] dl_x, dl_y, rl_x, rl_y, sl_x, sl_y;
  logic signed [SC_W-1:0]  sd_q, cd_q, sr_q, cr_q, ss_q, cs_q;

  always_comb begin
    dl_x = rot_dl[CORDIC_STAGES].x;
    dl_y = rot_dl[CORDIC_STAGES].y;
    rl_x = rot_rl[CORDIC_STAGES].x;
    rl_y = rot_rl[CORDIC_STAGES].y;
    sl_x = rot_sl[CORDIC_STAGES].x;
    sl_y = rot_sl[CORDIC_STAGES].y;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q <= SC_W'(rot_dl[CORDIC_STAGES].flag ? -dl_y : dl_y);
      cd_q <= SC_W'(rot_dl[CORDIC_STAGES].flag ? -dl_x : dl_x);
      sr_q <= SC_W'(rot_rl[CORDIC_STAGES].flag ? -rl_y : rl_y);
      cr_q <= SC_W'(rot_rl[CORDIC_STAGES].flag ? -rl_x : rl_x);
      ss_q <= SC_W'(rot_sl[CORDIC_STAGES].flag ? -sl_y : sl_y);
      cs_q <= SC_W'(rot_sl[CORDIC_STAGES].flag ? -sl_x : sl_x);
    end
  end

  // First product stage; Q30 products floor by the arithmetic shift.
  logic signed [2*SC_W-1:0] pa, pb, pc, pd, pf;
  logic signed [SC_W-1:0]   a1_q, b1_q, c1_q, d1_q, f1_q, cd1_q;

  always_comb begin
    pa = sd_q * cr_q;
    pb = cs_q * sr_q;
    pc = ss_q * cr_q;
    pd = sd_q * cs_q;
    pf = sr_q * cs_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q  <= pa[PROD_SHIFT+SC_W-1:PROD_SHIFT];
      b1_q  <= pb[PROD_SHIFT+SC_W-1:PROD_SHIFT];
      c1_q  <= pc[PROD_SHIFT+SC_W-1:PROD_SHIFT];
      d1_q  <= pd[PROD_SHIFT+SC_W-1:PROD_SHIFT];
      f1_q  <= pf[PROD_SHIFT+SC_W-1:PROD_SHIFT];
      cd1_q <= cd_q;
    end
  end

  // Second product stage: the terms scaled by cos(dlon).
  logic signed [2*SC_W-1:0] pg, ph;
  logic signed [SC_W-1:0]   a2_q, b2_q, c2_q, d2_q, g2_q, h2_q;

  always_comb begin
    pg = c1_q * cd1_q;
    ph = f1_q * cd1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a2_q <= a1_q;
      b2_q <= b1_q;
      c2_q <= c1_q;
      d2_q <= d1_q;
      g2_q <= pg[PROD_SHIFT+SC_W-1:PROD_SHIFT];
      h2_q <= ph[PROD_SHIFT+SC_W-1:PROD_SHIFT];
    end
  end

  // Arguments of the two arctangents.
  logic signed [VEC_W-1:0] x1_q, y1_q, x2_q, y2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y1_q <= VEC_W'(a2_q);
      x1_q <= VEC_W'(b2_q) - VEC_W'(g2_q);
      y2_q <= VEC_W'(d2_q);
      x2_q <= VEC_W'(c2_q) - VEC_W'(h2_q);
    end
  end

  // Quadrant pre-rotation for atan2; the flag marks a zero vector.
  function automatic cordic_vec_t atan_prep(input logic signed [VEC_W-1:0] x,
                                            input logic signed [VEC_W-1:0] y);
    cordic_vec_t v;
    v.flag = (x == '0) && (y == '0);
    v.x    = x;
    v.y    = y;
    v.z    = '0;
    if (x[VEC_W-1]) begin
      if (!y[VEC_W-1]) begin
        v.x = y;
        v.y = -x;
        v.z = HALF_PI_C;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -HALF_PI_C;
      end
    end
    return v;
  endfunction

  cordic_vec_t vec_a [CORDIC_STAGES+1];
  cordic_vec_t vec_b [CORDIC_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vec_a[0] <= atan_prep(x1_q, y1_q);
      vec_b[0] <= atan_prep(x2_q, y2_q);
    end
  end

  for (g = 0; g < CORDIC_STAGES; g++) begin : g_vec
    gcbd_cordic_cell #(.STAGE(g), .VECTORING(1'b1), .FRAC_BITS(FRAC_BITS)) u_ini (
      .clk_i, .en_i(adv), .vec_i(vec_a[g]), .vec_o(vec_a[g+1])
    );
    gcbd_cordic_cell #(.STAGE(g), .VECTORING(1'b1), .FRAC_BITS(FRAC_BITS)) u_fin (
      .clk_i, .en_i(adv), .vec_i(vec_b[g]), .vec_o(vec_b[g+1])
    );
  end

  // Initial bearing wrapped into [0, 2pi); raw final bearing pi - atan2.
  logic signed [ANG_W-1:0] ini, ini_w, z_fin;
  logic signed [ANG_W-1:0] ini_q, fin_raw_q;

  always_comb begin
    ini   = vec_a[CORDIC_STAGES].flag ? '0 : vec_a[CORDIC_STAGES].z;
    z_fin = vec_b[CORDIC_STAGES].flag ? '0 : vec_b[CORDIC_STAGES].z;
    if (ini[ANG_W-1]) begin
      ini_w = ini + TWO_PI_C;
    end else if (ini >= TWO_PI_C) begin
      ini_w = ini - TWO_PI_C;
    end else begin
      ini_w = ini;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ini_q     <= ini_w;
      fin_raw_q <= PI_C - z_fin;
    end
  end

  // Difference, with the final bearing wrapped where it is negative.
  logic signed [ANG_W-1:0] diff_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (fin_raw_q[ANG_W-1]) begin
        diff_q <= ini_q - fin_raw_q - TWO_PI_C;
      end else begin
        diff_q <= ini_q - fin_raw_q;
      end
    end
  end

  // Clamp to [-2pi, 2pi].
  logic signed [31:0] res_d;

  always_comb begin
    if (diff_q > TWO_PI_C) begin
      res_d = 32'(TWO_PI_C);
    end else if (diff_q < -TWO_PI_C) begin
      res_d = 32'(-TWO_PI_C);
    end else begin
      res_d = 32'(diff_q);
    end
  end

  // Output register with a skid register behind it.
  logic               out_vld_q;
  logic signed [31:0] out_q;
  logic signed [31:0] skid_q;
  logic               push;
  logic               pop;

  assign push = adv & vld_q[PIPE_LEN-1];
  assign pop  = out_vld_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res_d;
      end
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign azimuth_offset_o = out_q;

`ifndef SYNTH
  // The skid register is only filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output register is empty");

  // An input transfer enters the valid row in the next cycle.
  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted item missing from the pipeline");

  // Delivered results stay within the clamp range.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (azimuth_offset_o <= TWO_PI_C && azimuth_offset_o >= -TWO_PI_C))
    else $error("result outside [-2pi, 2pi]");
`endif

endmodule

@@ bench/tb_great_circle_bearing_difference.sv @@
// ----------------------------------------------------------------------------
// Great-circle bearing difference testbench
// Directed corner positions followed by random position pairs, sent in bursts
// while the result side stalls. Every result is checked against a bit-exact
// CORDIC bearing predictor kept in this file.
// ----------------------------------------------------------------------------
module tb_great_circle_bearing_difference;
  import gcbd_pkg::*;

  localparam int FRAC       = 28;
  localparam int STAGES     = 24;
  localparam int LATENCY    = 12 + 2 * STAGES;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_ITEMS = 1850;
  localparam longint LON_MAX = 843314856;
  localparam longint LAT_MAX = 421657428;
  localparam longint GAIN_Q30 = 652032874;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [30:0] ref_longitude_i;
  logic signed [29:0] ref_latitude_i;
  logic signed [30:0] site_longitude_i;
  logic signed [29:0] site_latitude_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] azimuth_offset_o;

  // One position pair as it goes onto the input port.
  typedef struct packed {
    logic signed [30:0] rlon;
    logic signed [29:0] rlat;
    logic signed [30:0] slon;
    logic signed [29:0] slat;
  } pair_t;

  longint            arctan_lut[STAGES];
  longint            pi_fx;
  longint            half_pi_fx;
  longint            two_pi_fx;
  logic signed [31:0] offset_queue[$];
  int                sent_count;
  int                checked_count;
  int                error_count;
  int                cycle_count;
  bit                hold_done;

  great_circle_bearing_difference i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .ref_longitude_i  (ref_longitude_i),
    .ref_latitude_i   (ref_latitude_i),
    .site_longitude_i (site_longitude_i),
    .site_latitude_i  (site_latitude_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .azimuth_offset_o (azimuth_offset_o)
  );

  // Clock with a 10-unit period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Round a Q60 value to the angle format.
  function automatic longint to_angle(input longint v);
    return (v + (64'sd1 <<< (59 - FRAC))) >>> (60 - FRAC);
  endfunction

  // Angle constants and the atan(2^-i) table, from the power series.
  function automatic void build_angles();
    longint pi_q60;
    longint acc;
    longint term;
    pi_q60 = 64'sh3243F6A8885A308D;
    for (int i = 0; i < STAGES; i++) begin
      acc = 0;
      if (i == 0) begin
        acc = pi_q60 >>> 2;
      end else begin
        for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
          term = (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
          acc = (k % 2 == 1) ? acc - term : acc + term;
        end
      end
      arctan_lut[i] = to_angle(acc);
    end
    pi_fx      = to_angle(pi_q60);
    half_pi_fx = to_angle(pi_q60 >>> 1);
    two_pi_fx  = to_angle(pi_q60 * 2);
  endfunction

  // Sine and cosine in Q30 by CORDIC rotation after range reduction.
  function automatic void rotate_sc(input longint ang, output longint s, output longint c);
    longint r;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    r = ang % two_pi_fx;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (r > pi_fx) r -= two_pi_fx;
    else if (r < -pi_fx) r += two_pi_fx;
    if (r > half_pi_fx) begin
      r -= pi_fx;
      flip = 1'b1;
    end else if (r < -half_pi_fx) begin
      r += pi_fx;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= arctan_lut[i];
      end else begin
        x += dx; y -= dy; r += arctan_lut[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Four-quadrant arctangent by CORDIC vectoring; the origin maps to zero.
  function automatic longint vector_angle(input longint yi, input longint xi);
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = half_pi_fx;
      end else begin
        t = -y; y = x; x = t; z = -half_pi_fx;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_lut[i];
      end else begin
        x -= dx; y += dy; z -= arctan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  // Initial bearing minus final bearing for one pair.
  function automatic logic signed [31:0] bearing_offset(input pair_t p);
    longint sd, cd, sr, cr, ss, cs;
    longint init_b;
    longint final_b;
    longint diff;
    rotate_sc(longint'(p.rlon) - longint'(p.slon), sd, cd);
    rotate_sc(longint'(p.rlat), sr, cr);
    rotate_sc(longint'(p.slat), ss, cs);
    init_b = vector_angle(mul_q30(sd, cr), mul_q30(cs, sr) - mul_q30(mul_q30(ss, cr), cd));
    if (init_b < 0) init_b += two_pi_fx;
    if (init_b >= two_pi_fx) init_b -= two_pi_fx;
    final_b = pi_fx - vector_angle(mul_q30(sd, cs),
                                   mul_q30(cr, ss) - mul_q30(mul_q30(sr, cs), cd));
    if (final_b < 0) final_b += two_pi_fx;
    diff = init_b - final_b;
    if (diff > two_pi_fx) diff = two_pi_fx;
    if (diff < -two_pi_fx) diff = -two_pi_fx;
    return diff[31:0];
  endfunction

  // Random pair: mostly in range, sometimes any value the port holds.
  function automatic pair_t random_pair();
    pair_t p;
    if ($urandom_range(0, 9) == 0) begin
      p.rlon = 31'($urandom);
      p.rlat = 30'($urandom);
      p.slon = 31'($urandom);
      p.slat = 30'($urandom);
    end else begin
      p.rlon = 31'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
      p.rlat = 30'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
      p.slon = 31'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
      p.slat = 30'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
    end
    return p;
  endfunction

  // Offer one pair and hold it until the transfer; then maybe leave a gap.
  task automatic send_pair(input pair_t p, input int gap);
    in_valid_i       <= 1'b1;
    ref_longitude_i  <= p.rlon;
    ref_latitude_i   <= p.rlat;
    site_longitude_i <= p.slon;
    site_latitude_i  <= p.slat;
    do @(posedge clk_i); while (!in_ready_o);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Predict on each input transfer.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      offset_queue.push_back(bearing_offset({ref_longitude_i, ref_latitude_i,
                                             site_longitude_i, site_latitude_i}));
      sent_count++;
    end
  end

  // Check each output transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (offset_queue.size() == 0) begin
        $error("azimuth_offset: unexpected result %0d", azimuth_offset_o);
        error_count++;
      end else begin
        if (azimuth_offset_o !== offset_queue[0]) begin
          $error("azimuth_offset: expected %0d, actual %0d", offset_queue[0],
                 azimuth_offset_o);
          error_count++;
        end
        void'(offset_queue.pop_front());
        checked_count++;
      end
    end
  end

  // Result side: changing stall patterns, plus one long hold-off.
  initial begin
    int mode;
    out_ready_i = 1'b0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_count >= 500) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (cycle_count % 150 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 1) == 1);
        2:       out_ready_i <= (cycle_count % 7 < 3);
        default: out_ready_i <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus: directed corners, then random bursts.
  initial begin
    pair_t corners[$];
    int burst;
    build_angles();
    sent_count = 0;
    checked_count = 0;
    error_count = 0;
    cycle_count = 0;
    hold_done = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    ref_longitude_i = '0;
    ref_latitude_i = '0;
    site_longitude_i = '0;
    site_latitude_i = '0;

    // CORDIC residues make every value here predictor-checked.
    corners = '{
      '{31'sd0, 30'sd0, 31'sd0, 30'sd0},
      '{31'(LON_MAX), 30'(LAT_MAX), 31'(LON_MAX), 30'(LAT_MAX)},
      '{31'(-LON_MAX), 30'(-LAT_MAX), 31'(-LON_MAX), 30'(-LAT_MAX)},
      '{31'(LON_MAX), 30'sd0, 31'(-LON_MAX), 30'sd0},
      '{31'(-LON_MAX), 30'(LAT_MAX), 31'(LON_MAX), 30'(-LAT_MAX)},
      '{31'sh3FFFFFFF, 30'sh1FFFFFFF, 31'sh40000000, 30'sh20000000},
      '{31'sh40000000, 30'sh20000000, 31'sh3FFFFFFF, 30'sh1FFFFFFF},
      '{31'sd100000, 30'sd0, 31'sd0, 30'(LAT_MAX)},
      '{31'sd0, 30'(LAT_MAX), 31'sd0, 30'(-LAT_MAX)},
      '{31'(LON_MAX), 30'sd12345678, 31'sd0, 30'sd12345678},
      '{31'sd210828714, 30'sd140552476, 31'sd210828714, 30'sd140552476},
      '{31'sd1, 30'sd1, 31'sd0, 30'sd0},
      '{31'sd0, 30'sd0, 31'sd0, 30'(LAT_MAX)},
      '{31'sd0, 30'sd0, 31'sd0, 30'(-LAT_MAX)}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corners[i]) send_pair(corners[i], $urandom_range(0, 2));

    burst = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Once, let everything drain with the input idle.
      if (n == 1200) begin
        in_valid_i <= 1'b0;
        wait (offset_queue.size() == 0);
        @(posedge clk_i);
      end
      if (burst == 0) burst = $urandom_range(1, 40);
      burst--;
      send_pair(random_pair(), (burst == 0) ? $urandom_range(1, 12) : 0);
    end
    in_valid_i <= 1'b0;

    wait (offset_queue.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("Covered %0d corner and random position pairs, %0d results checked,",
             sent_count, checked_count);
    $display("with input bursts, output stalls, a long output hold-off and a drain.");
    if (error_count == 0 && offset_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/gcbd_pkg.sv
hdl/gcbd_angle_reduce.sv
hdl/gcbd_cordic_cell.sv
hdl/great_circle_bearing_difference.sv
bench/tb_great_circle_bearing_difference.sv
